// ===== sv/pei_pkg.sv =====
// pei_pkg: shared constants, codes and item types of the pulse energy integrator
// no dependencies; imported by every module of the block
package pei_pkg;

  localparam int REC_LEN  = 2500;
  localparam int BASE_LEN = 250;
  localparam int NUM_BINS = 70;

  localparam int CNT_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;
  localparam int SUM_ALL_W  = 30;
  localparam int SUM_BASE_W = 25;
  localparam int SQ_ALL_W   = 44;
  localparam int SQ_BASE_W  = 39;

  // record queue between accumulator and arithmetic back end (depth a power of two)
  localparam int REC_Q_DEPTH = 2;
  localparam int REC_Q_AW    = 1;
  localparam int REC_Q_CW    = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_LOW    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE   = 8'd3;

  localparam logic [1:0] RANGE_IN    = 2'd0;
  localparam logic [1:0] RANGE_BELOW = 2'd1;
  localparam logic [1:0] RANGE_ABOVE = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] energy;
    logic [6:0]         bin_index;
    logic [1:0]         range_code;
    logic               short_record;
  } out_t;

  typedef struct packed {
    logic signed [SUM_ALL_W-1:0]  sum_all;
    logic signed [SUM_BASE_W-1:0] sum_base;
    logic [SQ_ALL_W-1:0]          sumsq_all;
    logic [SQ_BASE_W-1:0]         sumsq_base;
    logic                         short_rec;
  } rec_t;

  typedef struct packed {
    logic [REC_Q_CW-1:0] count;
  } rq_stat_t;

  typedef struct packed {
    logic signed [31:0] coef_linear;
    logic signed [31:0] coef_square;
    logic signed [31:0] hist_low;
    logic [31:0]        bin_scale;
  } cfg_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

// ===== sv/pei_front.sv =====
// pei_front: sample counter, squarer and the four record sums
// depends on pei_pkg; hands each finished record to the record queue
module pei_front import pei_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_t      in_item,
  input  rq_stat_t rq_stat,
  output logic     full,
  output logic     rec_push,
  output rec_t     rec_data
);

  logic                         accept;
  logic                         in_rec;
  logic                         in_base;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;
  logic [CNT_W-1:0]             cnt_inc;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  logic                         s1_valid_r;
  logic                         s1_last_r;
  logic                         s1_short_r;
  logic                         s1_add_all_r;
  logic                         s1_add_base_r;
  logic signed [SAMPLE_W-1:0]   s1_x_r;
  logic [SQ_W-1:0]              s1_sq_r;

  logic signed [SUM_ALL_W-1:0]  sum_all_r, sum_all_nxt;
  logic signed [SUM_BASE_W-1:0] sum_base_r, sum_base_nxt;
  logic [SQ_ALL_W-1:0]          sumsq_all_r, sumsq_all_nxt;
  logic [SQ_BASE_W-1:0]         sumsq_base_r, sumsq_base_nxt;

  // keep a slot free for a marked item still in the summing stage
  assign full = ({1'b0, rq_stat.count} + (REC_Q_CW+1)'(s1_valid_r && s1_last_r))
                >= (REC_Q_CW+1)'(REC_Q_DEPTH);
  assign accept = push && !full;

  assign in_rec  = cnt_r < CNT_W'(REC_LEN);
  assign in_base = cnt_r < CNT_W'(BASE_LEN);
  assign cnt_inc = in_rec ? cnt_r + 1'b1 : cnt_r;
  assign sq_full = in_item.sample * in_item.sample;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_item.last_sample ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r        <= in_item.sample;
      s1_sq_r       <= sq_full[SQ_W-1:0];
      s1_last_r     <= in_item.last_sample;
      s1_short_r    <= cnt_inc < CNT_W'(REC_LEN);
      s1_add_all_r  <= in_rec;
      s1_add_base_r <= in_rec && in_base;
    end
  end

  always_comb begin
    sum_all_nxt    = sum_all_r + (s1_add_all_r ? SUM_ALL_W'(s1_x_r) : '0);
    sumsq_all_nxt  = sumsq_all_r + (s1_add_all_r ? SQ_ALL_W'(s1_sq_r) : '0);
    sum_base_nxt   = sum_base_r + (s1_add_base_r ? SUM_BASE_W'(s1_x_r) : '0);
    sumsq_base_nxt = sumsq_base_r + (s1_add_base_r ? SQ_BASE_W'(s1_sq_r) : '0);
  end

  assign rec_push            = s1_valid_r && s1_last_r;
  assign rec_data.sum_all    = sum_all_nxt;
  assign rec_data.sum_base   = sum_base_nxt;
  assign rec_data.sumsq_all  = sumsq_all_nxt;
  assign rec_data.sumsq_base = sumsq_base_nxt;
  assign rec_data.short_rec  = s1_short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_all_r    <= '0;
      sum_base_r   <= '0;
      sumsq_all_r  <= '0;
      sumsq_base_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        sum_all_r    <= '0;
        sum_base_r   <= '0;
        sumsq_all_r  <= '0;
        sumsq_base_r <= '0;
      end else begin
        sum_all_r    <= sum_all_nxt;
        sum_base_r   <= sum_base_nxt;
        sumsq_all_r  <= sumsq_all_nxt;
        sumsq_base_r <= sumsq_base_nxt;
      end
    end
  end

endmodule

// ===== sv/pei_rec_fifo.sv =====
// pei_rec_fifo: short queue of finished record sums between front and back end
// depends on pei_pkg for the record type and depth
module pei_rec_fifo import pei_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rec_t     wr_data,
  input  logic     pop,
  output logic     rd_valid,
  output rec_t     rd_data,
  output rq_stat_t stat
);

  rec_t                mem [REC_Q_DEPTH];
  logic [REC_Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [REC_Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [REC_Q_CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_valid    = count_r != '0;
  assign rd_data     = mem[rd_ptr_r];
  assign stat.count  = count_r;

endmodule

// ===== sv/pei_back.sv =====
// pei_back: per-record arithmetic sequencer, integrals, weighted energy, binning
// depends on pei_pkg; one shared 27x32 multiplier, result held in an output register
module pei_back import pei_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  rec_t       rec_data,
  output logic       rec_pop,
  input  cfg_t       cfg,
  input  logic       pop,
  output logic       empty,
  output out_t       out_item,
  output back_stat_t stat
);

  localparam int I1_W  = 38;
  localparam int I2_W  = 52;
  localparam int LO_W  = 26;
  localparam int MA_W  = LO_W + 1;
  localparam int MB_W  = 32;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = 84;
  localparam int FRAC  = 40;
  localparam int Q_W   = ACC_W - FRAC;

  localparam logic signed [I1_W-1:0] BASE_K1 = I1_W'(BASE_LEN);
  localparam logic signed [I1_W-1:0] REC_K1  = I1_W'(REC_LEN);
  localparam logic signed [I2_W-1:0] BASE_K2 = I2_W'(BASE_LEN);
  localparam logic signed [I2_W-1:0] REC_K2  = I2_W'(REC_LEN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_M4    = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;
  localparam logic [3:0] S_BIN   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic signed [I1_W-1:0]  a1_r, b1_r, i1_r;
  logic signed [I2_W-1:0]  a2_r, b2_r, i2_r;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [P_W-1:0]   prod_r;
  logic                    prod_hi_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]        rsum;
  logic [Q_W-1:0]          q;
  logic signed [31:0]      energy_sat;
  logic signed [31:0]      energy_r;
  logic signed [32:0]      d_r;
  logic                    below_r;
  logic [63:0]             bprod_r;
  logic [31:0]             bin;
  logic                    short_r;
  logic                    slot_free;
  logic                    load_out;
  logic                    out_valid_r;
  out_t                    out_r;
  out_t                    res;

  assign slot_free = !out_valid_r || pop;
  assign load_out  = (state_r == S_FIN) && slot_free;
  assign rec_pop   = (state_r == S_IDLE) && rec_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (rec_valid) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_SUB;
      S_SUB:   state_nxt = S_BIN;
      S_BIN:   state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // integrals split into an unsigned low part and a signed high part
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_M0: begin
        ma = $signed({1'b0, i1_r[LO_W-1:0]});
        mb = cfg.coef_linear;
      end
      S_M1: begin
        ma = MA_W'($signed(i1_r[I1_W-1:LO_W]));
        mb = cfg.coef_linear;
      end
      S_M2: begin
        ma = $signed({1'b0, i2_r[LO_W-1:0]});
        mb = cfg.coef_square;
      end
      S_M3: begin
        ma = MA_W'($signed(i2_r[I2_W-1:LO_W]));
        mb = cfg.coef_square;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);
  assign addend   = prod_hi_r ? (prod_ext <<< LO_W) : prod_ext;

  // round half up, then saturate the 44 bit quotient to 32 bits
  assign rsum = acc_r + (ACC_W'(1) << (FRAC - 1));
  assign q    = rsum[ACC_W-1:FRAC];

  always_comb begin
    if ((&q[Q_W-1:31]) || !(|q[Q_W-1:31])) begin
      energy_sat = $signed(q[31:0]);
    end else if (q[Q_W-1]) begin
      energy_sat = 32'sh8000_0000;
    end else begin
      energy_sat = 32'sh7fff_ffff;
    end
  end

  assign bin = bprod_r[63:32];

  always_comb begin
    res.energy       = energy_r;
    res.short_record = short_r;
    if (below_r) begin
      res.range_code = RANGE_BELOW;
      res.bin_index  = '0;
    end else if (bin >= 32'(NUM_BINS)) begin
      res.range_code = RANGE_ABOVE;
      res.bin_index  = '0;
    end else begin
      res.range_code = RANGE_IN;
      res.bin_index  = bin[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      a1_r    <= I1_W'(rec_data.sum_all) * BASE_K1;
      b1_r    <= I1_W'(rec_data.sum_base) * REC_K1;
      a2_r    <= $signed(I2_W'(rec_data.sumsq_all)) * BASE_K2;
      b2_r    <= $signed(I2_W'(rec_data.sumsq_base)) * REC_K2;
      short_r <= rec_data.short_rec;
    end
    if (state_r == S_DIFF) begin
      i1_r  <= a1_r - b1_r;
      i2_r  <= a2_r - b2_r;
      acc_r <= '0;
    end
    prod_r    <= ma * mb;
    prod_hi_r <= (state_r == S_M1) || (state_r == S_M3);
    if ((state_r == S_M1) || (state_r == S_M2) || (state_r == S_M3) ||
        (state_r == S_M4)) begin
      acc_r <= acc_r + addend;
    end
    if (state_r == S_ROUND) begin
      energy_r <= energy_sat;
    end
    if (state_r == S_SUB) begin
      d_r <= 33'(energy_r) - 33'(cfg.hist_low);
    end
    if (state_r == S_BIN) begin
      below_r <= d_r[32];
      bprod_r <= 64'(d_r[31:0]) * 64'(cfg.bin_scale);
    end
    if (load_out) begin
      out_r <= res;
    end
  end

  assign empty     = !out_valid_r;
  assign out_item  = out_r;
  assign stat.busy = state_r != S_IDLE;

endmodule

// ===== sv/pulse_energy_integrator_top.sv =====
// pulse_energy_integrator_top: configuration registers and the front/queue/back chain
// depends on pei_pkg, pei_front, pei_rec_fifo and pei_back
//
// Samples are taken one per clock while full is low; the accumulator sums each
// sample and its square over the record and over the leading baseline window.
// A marked sample closes the record; its sums pass through the summing stage
// register into a two-entry queue. The arithmetic back end works on one record
// at a time, in order: constant scaling, integrals, four passes through one
// shared 27x32 multiplier, rounding, edge offset and bin multiply. Samples flow
// at one per cycle until both queue entries are taken, counting a marked sample
// still in the summing stage; full then holds back every sample, marked or not,
// until the back end frees an entry. Results wait in an output register until
// popped.
// Configuration writes are always ready and should be made while no record is
// in flight.
module pulse_energy_integrator_top import pei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r;
  rq_stat_t   rq_stat;
  back_stat_t bstat;
  rec_t       rec_wr;
  rec_t       rec_rd;
  logic       rec_push;
  logic       rec_pop;
  logic       rec_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEF_LINEAR: cfg_r.coef_linear <= $signed(cfg_data);
        CFG_COEF_SQUARE: cfg_r.coef_square <= $signed(cfg_data);
        CFG_HIST_LOW:    cfg_r.hist_low    <= $signed(cfg_data);
        CFG_BIN_SCALE:   cfg_r.bin_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  pei_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .rq_stat  (rq_stat),
    .full     (full),
    .rec_push (rec_push),
    .rec_data (rec_wr)
  );

  pei_rec_fifo u_rec_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .wr_data  (rec_wr),
    .pop      (rec_pop),
    .rd_valid (rec_valid),
    .rd_data  (rec_rd),
    .stat     (rq_stat)
  );

  pei_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_data  (rec_rd),
    .rec_pop   (rec_pop),
    .cfg       (cfg_r),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item),
    .stat      (bstat)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_stat.count <= REC_Q_CW'(REC_Q_DEPTH))
    else $error("record queue over its depth");

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> (rq_stat.count < REC_Q_CW'(REC_Q_DEPTH) || rec_pop))
    else $error("record pushed into a full queue");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && rq_stat.count == '0))
    else $error("reset left an item pending");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !bstat.busy && rq_stat.count == '0) |=> empty)
    else $error("item appeared with no record in progress");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for pulse_energy_integrator_top
// depends on pei_pkg and the block's rtl; records are streamed with random gaps and the
// results are checked against a cycle-free model of the record sums and energy arithmetic
module tb_top;
  import pei_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 1450;
  localparam int RESULT_TARGET = 48;
  localparam int GAP_PERCENT   = 9;

  typedef enum int {AMP_FULL, AMP_SMALL, AMP_POS_MAX, AMP_NEG_MAX} amp_e;

  class energy_checker;
    logic signed [31:0] coef_lin, coef_sq, hist_lo;
    logic [31:0]        bin_scl;
    int unsigned        n_samples;
    longint             sum_rec, sum_win, sq_rec, sq_win;
    out_t               pending_pulses[$];
    int unsigned        errors;

    function new();
      coef_lin = '0;
      coef_sq  = '0;
      hist_lo  = '0;
      bin_scl  = '0;
      errors   = 0;
      clear_record();
    endfunction

    function void clear_record();
      n_samples = 0;
      sum_rec   = 0;
      sum_win   = 0;
      sq_rec    = 0;
      sq_win    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COEF_LINEAR: coef_lin = data;
        CFG_COEF_SQUARE: coef_sq  = data;
        CFG_HIST_LOW:    hist_lo  = data;
        CFG_BIN_SCALE:   bin_scl  = data;
        default: ;
      endcase
    endfunction

    // accumulate one accepted sample; a marked sample closes the record
    function void take_sample(in_t it);
      longint              x, sq, i1, i2, d;
      logic signed [127:0] a1, c1, a2, c2, acc, e_max, e_min;
      logic signed [31:0]  e;
      logic [63:0]         du, prod, bin;
      logic [1:0]          code;
      out_t                r;
      x = $signed(it.sample);
      if (n_samples < REC_LEN) begin
        sq = x * x;
        sum_rec += x;
        sq_rec  += sq;
        if (n_samples < BASE_LEN) begin
          sum_win += x;
          sq_win  += sq;
        end
        n_samples++;
      end
      if (!it.last_sample) return;

      i1 = BASE_LEN * sum_rec - REC_LEN * sum_win;
      i2 = BASE_LEN * sq_rec - REC_LEN * sq_win;
      a1 = i1;
      c1 = coef_lin;
      a2 = i2;
      c2 = coef_sq;
      // round half up at bit 40, then floor
      acc = a1 * c1 + a2 * c2 + 128'sh80_0000_0000;
      acc = acc >>> 40;
      e_max = 128'sh7FFF_FFFF;
      e_min = -e_max - 1;
      if (acc > e_max) e = 32'h7FFF_FFFF;
      else if (acc < e_min) e = 32'h8000_0000;
      else e = acc[31:0];

      d = e;
      d = d - hist_lo;
      bin = '0;
      code = RANGE_IN;
      if (d < 0) begin
        code = RANGE_BELOW;
      end else begin
        du = d;
        prod = du * {32'd0, bin_scl};
        bin = prod >> 32;
        if (bin >= NUM_BINS) begin
          code = RANGE_ABOVE;
          bin = '0;
        end
      end
      r.energy       = e;
      r.bin_index    = bin[6:0];
      r.range_code   = code;
      r.short_record = (n_samples < REC_LEN);
      pending_pulses.push_back(r);
      clear_record();
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pulse(out_t got);
      out_t want;
      if (pending_pulses.size() == 0) begin
        $error("result with none expected: energy %0d", got.energy);
        errors++;
        return;
      end
      want = pending_pulses.pop_front();
      compare_field("energy", want.energy, got.energy);
      compare_field("bin_index", want.bin_index, got.bin_index);
      compare_field("range_code", want.range_code, got.range_code);
      compare_field("short_record", want.short_record, got.short_record);
    endfunction
  endclass

  logic                  clk, rst_n;
  logic                  push, full, empty, pop;
  in_t                   in_item;
  out_t                  out_item;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  energy_checker chk = new();
  int unsigned   n_items, n_records, cycle_count;
  bit            steady_run, hold_off_req;

  pulse_energy_integrator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_gap();
    return !steady_run && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic mark);
    in_t it;
    it.sample      = s;
    it.last_sample = mark;
    if (take_gap()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    chk.take_sample(it);
    n_items++;
    if (mark) n_records++;
  endtask

  function automatic logic signed [15:0] pick_sample(amp_e mode, int amp);
    case (mode)
      AMP_FULL:    return 16'($urandom);
      AMP_SMALL:   return 16'($urandom_range(0, 2 * amp) - amp);
      AMP_POS_MAX: return 16'sh7FFF;
      default:     return 16'sh8000;
    endcase
  endfunction

  task automatic send_record(input int unsigned len, input amp_e mode);
    int amp;
    amp = 1 << $urandom_range(0, 10);
    for (int unsigned i = 0; i < len; i++)
      send_sample(pick_sample(mode, amp), i == len - 1);
  endtask

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 24);
    if (r < 82) return $urandom_range(BASE_LEN - 10, BASE_LEN + 10);
    return $urandom_range(25, 120);
  endfunction

  function automatic amp_e pick_amp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return AMP_FULL;
    if (r < 80) return AMP_SMALL;
    if (r < 90) return AMP_POS_MAX;
    return AMP_NEG_MAX;
  endfunction

  // four real registers, then one index past the map that must change nothing
  task automatic program_regs(input logic [31:0] lin, input logic [31:0] sq,
                              input logic [31:0] low, input logic [31:0] scale);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx = '{CFG_COEF_LINEAR, CFG_COEF_SQUARE, CFG_HIST_LOW, CFG_BIN_SCALE,
            CFG_IDX_W'($urandom_range(CFG_BIN_SCALE + 1, 255))};
    val = '{lin, sq, low, scale, $urandom};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      chk.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] wild_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: begin
        w = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -w : w;
      end
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] lin, sq, low, scale;
    if ($urandom_range(0, 2) != 0) begin
      // scaled so that small pulses land inside the histogram
      lin = 32'h1 << $urandom_range(18, 30);
      if ($urandom_range(0, 1)) lin = -lin;
      sq = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 2048)) - 32'd1024;
      low = -32'($urandom_range(0, 65536));
      scale = $urandom_range(32'h0040_0000, 32'h1000_0000);
    end else begin
      lin   = wild_word();
      sq    = wild_word();
      low   = wild_word();
      scale = wild_word();
    end
    program_regs(lin, sq, low, scale);
  endtask

  // nothing left in flight: all results in, then the back end's own latency
  task automatic settle();
    push <= 1'b0;
    while (chk.pending_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random pops, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    bit          want;
    hold_left = 0;
    pop <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      want = (hold_left == 0) && !take_gap();
      if (hold_left > 0) hold_left--;
      pop <= want;
      @(posedge clk);
      if (pop && !empty) chk.check_pulse(out_item);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int unsigned phase;
    n_items      = 0;
    n_records    = 0;
    steady_run   = 1'b0;
    hold_off_req = 1'b0;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset value: every energy is zero
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    settle();

    // extreme weights, lowest edge, widest scale
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0007, 1'b1);
    settle();

    // opposite extremes: top edge, zero scale, so everything lies below
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'shFFFF, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    settle();

    // bins of width 64 from -4096: in range, and past the last bin
    program_regs(32'h4000_0000, 32'h0000_0000, 32'hFFFF_F000, 32'h0400_0000);
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd2, 1'b1);
    send_sample(-16'sd2000, 1'b1);
    settle();

    phase = 0;
    while (phase < 4 || n_items < ITEM_TARGET || n_records < RESULT_TARGET) begin
      random_config();
      if (phase == 1) steady_run = 1'b1;
      if (phase == 2) begin
        // hold results back while short records pile up behind them
        hold_off_req = 1'b1;
        repeat (20) send_record($urandom_range(1, 3), AMP_SMALL);
      end
      repeat ($urandom_range(3, 6)) send_record(pick_len(), pick_amp());
      settle();
      steady_run = 1'b0;
      phase++;
    end

    settle();
    if (chk.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
